// ===== rtl/core/tpba_pkg.sv =====
// package for the two-pool bitmap page allocator
// shared constants, status codes and register indexes; no dependencies
`timescale 1ns / 1ps
package tpba_pkg;
    localparam int POOL_PAGES = 1024;
    localparam int WORD_BITS  = 32;
    localparam int WORDS      = POOL_PAGES / WORD_BITS;
    localparam int WADDR_W    = $clog2(WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int IDX_W      = $clog2(POOL_PAGES);
    localparam int CNT_W      = 11;
    localparam int PAGE_W     = 20;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_NO_PAGES = 3'd2;
    localparam logic [2:0] ST_NO_POOL  = 3'd3;
    localparam logic [2:0] ST_NOT_USED = 3'd4;

    localparam logic [1:0] REG_KBASE  = 2'd0;
    localparam logic [1:0] REG_KPAGES = 2'd1;
    localparam logic [1:0] REG_UBASE  = 2'd2;
    localparam logic [1:0] REG_UPAGES = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN, S_MARK_RD, S_MARK,
        S_CHK_RD, S_CHK, S_FREE_RD, S_FREE, S_DONE
    } state_t;
endpackage

// ===== rtl/core/two_pool_bitmap_page_allocator_unit.sv =====
// two-pool first-fit page allocator, top level
// depends on tpba_pkg; holds both used-page bitmaps in one 32-bit word memory
// After reset the block clears its bitmap memory (32 words per pool) and
// takes no request until that pass is done. Each request then runs through a sequencer that
// reads one 32-bit bitmap word from a single-port memory and then walks it one
// bit per cycle. A zero count, a page outside both pools or a free that runs past the pool
// end goes from decode straight to the result register without reading the memory.
// An allocate scans the pool from word 0, reading each word and then examining its pages
// one at a time until a fit or the pool end, then marks the run the same way. A free checks
// that every page of the run is in use and then clears the run at the same pace.
// Results sit in an output register, so the next request can be taken while one waits.
`timescale 1ns / 1ps
module two_pool_bitmap_page_allocator_unit
    import tpba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // page_count[10:0], page_number[30:11], zero fill
    input  logic [1:0]  s_tuser,   // kind[0], from_user_pool[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // first_page[19:0], status[22:20], zero fill
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    // memory: kernel words at 0..WORDS-1, user at WORDS..2*WORDS-1
    logic [WORD_BITS-1:0] mem [2*WORDS];
    logic [WORD_BITS-1:0] rd_reg;
    logic                 mem_we;
    logic [WADDR_W:0]     mem_addr;
    logic [WORD_BITS-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_reg <= mem[mem_addr];
    end

    logic [PAGE_W-1:0] kbase_reg, ubase_reg;
    logic [CNT_W-1:0]  kpages_reg, upages_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kbase_reg <= '0; kpages_reg <= '0; ubase_reg <= '0; upages_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KBASE:  kbase_reg  <= cfg_data;
                REG_KPAGES: kpages_reg <= cfg_data[CNT_W-1:0];
                REG_UBASE:  ubase_reg  <= cfg_data;
                REG_UPAGES: upages_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    state_t            state_reg, state_next;
    logic              kind_reg, kind_next, pool_reg, pool_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [CNT_W-1:0]  size_reg, size_next;     // usable pool size
    logic [CNT_W-1:0]  pos_reg, pos_next;       // current page index, may reach 1024
    logic [CNT_W-1:0]  run_reg, run_next;
    logic [CNT_W-1:0]  start_reg, start_next;   // run start index
    logic [CNT_W-1:0]  endp_reg, endp_next;     // one past run end
    logic [WORD_BITS-1:0] wbuf_reg, wbuf_next;
    logic [PAGE_W-1:0] res_page_reg, res_page_next;   // result being built
    logic [2:0]        res_st_reg, res_st_next;
    logic              out_v_reg, out_v_next;
    logic [PAGE_W-1:0] out_page_reg, out_page_next;
    logic [2:0]        out_st_reg, out_st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pos_reg   <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next; pool_reg <= pool_next; count_reg <= count_next;
        page_reg <= page_next; size_reg <= size_next; run_reg <= run_next;
        start_reg <= start_next; endp_reg <= endp_next; wbuf_reg <= wbuf_next;
        res_page_reg <= res_page_next; res_st_reg <= res_st_next;
        out_page_reg <= out_page_next; out_st_reg <= out_st_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {1'b0, out_st_reg, out_page_reg};

    logic [CNT_W-1:0] kusable, uusable;
    assign kusable = (kpages_reg > CNT_W'(POOL_PAGES)) ? CNT_W'(POOL_PAGES) : kpages_reg;
    assign uusable = (upages_reg > CNT_W'(POOL_PAGES)) ? CNT_W'(POOL_PAGES) : upages_reg;

    logic [PAGE_W:0] kend, uend;
    logic            in_k, in_u;
    logic [PAGE_W-1:0] koff, uoff;
    assign kend = {1'b0, kbase_reg} + (PAGE_W+1)'(kusable);
    assign uend = {1'b0, ubase_reg} + (PAGE_W+1)'(uusable);
    assign in_k = (page_reg >= kbase_reg) && ({1'b0, page_reg} < kend);
    assign in_u = (page_reg >= ubase_reg) && ({1'b0, page_reg} < uend);
    assign koff = page_reg - kbase_reg;
    assign uoff = page_reg - ubase_reg;

    logic [BIT_W-1:0] bsel;
    logic             cur_bit, word_last;
    logic [WADDR_W:0] waddr;
    logic [CNT_W:0]   endsum;
    assign bsel      = pos_reg[BIT_W-1:0];
    assign cur_bit   = wbuf_reg[bsel];
    assign word_last = (bsel == BIT_W'(WORD_BITS-1));
    assign waddr     = {pool_reg, pos_reg[IDX_W-1:BIT_W]};

    always_comb
    begin
        state_next = state_reg;
        kind_next = kind_reg; pool_next = pool_reg; count_next = count_reg;
        page_next = page_reg; size_next = size_reg; pos_next = pos_reg;
        run_next = run_reg; start_next = start_reg; endp_next = endp_reg;
        wbuf_next = wbuf_reg;
        res_page_next = res_page_reg; res_st_next = res_st_reg;
        out_v_next = out_v_reg && !m_tready;
        out_page_next = out_page_reg; out_st_next = out_st_reg;
        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = waddr;
        mem_wdata = wbuf_reg;
        endsum    = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = pos_reg[WADDR_W:0];
                mem_wdata = '0;
                pos_next  = pos_reg + 1'b1;
                if (pos_reg == CNT_W'(2*WORDS-1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    kind_next  = s_tuser[0];
                    pool_next  = s_tuser[1];
                    count_next = s_tdata[CNT_W-1:0];
                    page_next  = s_tdata[CNT_W+PAGE_W-1:CNT_W];
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                pos_next = '0;
                run_next = '0;
                res_page_next = '0;
                if (count_reg == '0)
                begin
                    res_st_next = ST_ZERO;
                    state_next  = S_DONE;
                end
                else if (!kind_reg)
                begin
                    size_next  = pool_reg ? uusable : kusable;
                    state_next = S_SCAN_RD;
                end
                else if (in_k || in_u)
                begin
                    pool_next = !in_k;
                    size_next = in_k ? kusable : uusable;
                    start_next = in_k ? CNT_W'(koff) : CNT_W'(uoff);
                    pos_next   = in_k ? CNT_W'(koff) : CNT_W'(uoff);
                    endsum = (CNT_W+1)'(in_k ? CNT_W'(koff) : CNT_W'(uoff))
                           + (CNT_W+1)'(count_reg);
                    endp_next  = CNT_W'(endsum);
                    if (endsum > (CNT_W+1)'(in_k ? kusable : uusable))
                    begin
                        res_st_next = ST_NOT_USED;
                        state_next  = S_DONE;
                    end
                    else
                        state_next = S_CHK_RD;
                end
                else
                begin
                    res_st_next = ST_NO_POOL;
                    state_next  = S_DONE;
                end
            end
            S_SCAN_RD:
            begin
                if (pos_reg >= size_reg)
                begin
                    res_st_next = ST_NO_PAGES;
                    state_next  = S_DONE;
                end
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (bsel == '0 && wbuf_reg != rd_reg)
                    wbuf_next = rd_reg;
                // first bit of a word comes straight from the read data
                if ((bsel == '0) ? rd_reg[0] : cur_bit)
                    run_next = '0;
                else
                    run_next = run_reg + 1'b1;
                if (bsel == '0)
                    wbuf_next = rd_reg;
                pos_next = pos_reg + 1'b1;
                if (!((bsel == '0) ? rd_reg[0] : cur_bit) && run_reg + 1'b1 == count_reg)
                begin
                    start_next = pos_reg + 1'b1 - count_reg;
                    endp_next  = pos_reg + 1'b1;
                    pos_next   = pos_reg + 1'b1 - count_reg;
                    res_page_next = (pool_reg ? ubase_reg : kbase_reg)
                                  + PAGE_W'(pos_reg + 1'b1 - count_reg);
                    res_st_next = ST_OK;
                    state_next  = S_MARK_RD;
                end
                else if (pos_reg + 1'b1 >= size_reg)
                begin
                    res_st_next = ST_NO_PAGES;
                    state_next  = S_DONE;
                end
                else if (word_last)
                    state_next = S_SCAN_RD;
            end
            S_MARK_RD, S_CHK_RD, S_FREE_RD:
            begin
                state_next = (state_reg == S_MARK_RD) ? S_MARK :
                             (state_reg == S_CHK_RD) ? S_CHK : S_FREE;
            end
            S_MARK, S_FREE:
            begin
                // set or clear bits of the run in this word, one per cycle
                wbuf_next = (pos_reg == start_reg || bsel == '0) ? rd_reg : wbuf_reg;
                wbuf_next[bsel] = (state_reg == S_MARK);
                pos_next = pos_reg + 1'b1;
                if (word_last || pos_reg + 1'b1 == endp_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = wbuf_next;
                    if (pos_reg + 1'b1 == endp_reg)
                    begin
                        res_st_next = ST_OK;
                        state_next  = S_DONE;
                    end
                    else
                        state_next = (state_reg == S_MARK) ? S_MARK_RD : S_FREE_RD;
                end
            end
            S_CHK:
            begin
                wbuf_next = (pos_reg == start_reg || bsel == '0) ? rd_reg : wbuf_reg;
                pos_next  = pos_reg + 1'b1;
                if (!wbuf_next[bsel])
                begin
                    res_st_next = ST_NOT_USED;
                    state_next  = S_DONE;
                end
                else if (pos_reg + 1'b1 == endp_reg)
                begin
                    pos_next   = start_reg;
                    state_next = S_FREE_RD;
                end
                else if (word_last)
                    state_next = S_CHK_RD;
            end
            S_DONE:
            begin
                if (!out_v_reg || m_tready)
                begin
                    out_v_next    = 1'b1;
                    out_page_next = res_page_reg;
                    out_st_next   = res_st_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
